### src/pointer_event_tracker_defines.svh
// Assertion macros for the pointer event tracker checks
`ifndef POINTER_EVENT_TRACKER_DEFINES_SVH
`define POINTER_EVENT_TRACKER_DEFINES_SVH

// same-cycle implication on clk, off during reset
`define PET_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pointer_event_tracker: check failed");

// next-cycle implication on clk, off during reset
`define PET_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pointer_event_tracker: check failed");

`endif

### src/pet_pkg.sv
// Types, codes and fixed widths shared by the pointer event tracker
package pet_pkg;
	localparam int DIM_W      = 16;
	localparam int SPAN_W     = 32;
	localparam int CODE_W     = 10;
	localparam int VAL_W      = 32;
	localparam int BTN_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// event types
	localparam logic [1:0] MODE_KEY = 2'd1;
	localparam logic [1:0] MODE_REL = 2'd2;
	localparam logic [1:0] MODE_ABS = 2'd3;

	// event codes
	localparam logic [CODE_W-1:0] CODE_AXIS_X     = 10'd0;
	localparam logic [CODE_W-1:0] CODE_AXIS_Y     = 10'd1;
	localparam logic [CODE_W-1:0] CODE_REL_WHEEL  = 10'd8;
	localparam logic [CODE_W-1:0] CODE_BTN_LEFT   = 10'd272;
	localparam logic [CODE_W-1:0] CODE_BTN_RIGHT  = 10'd273;
	localparam logic [CODE_W-1:0] CODE_BTN_MIDDLE = 10'd274;
	localparam logic [CODE_W-1:0] CODE_BTN_FINGER = 10'd325;
	localparam logic [CODE_W-1:0] CODE_BTN_TOUCH  = 10'd330;

	// button result codes
	localparam logic [BTN_W-1:0] BTN_NONE        = 4'd0;
	localparam logic [BTN_W-1:0] BTN_LEFT_DOWN   = 4'd1;
	localparam logic [BTN_W-1:0] BTN_LEFT_UP     = 4'd2;
	localparam logic [BTN_W-1:0] BTN_RIGHT_DOWN  = 4'd3;
	localparam logic [BTN_W-1:0] BTN_RIGHT_UP    = 4'd4;
	localparam logic [BTN_W-1:0] BTN_MIDDLE_DOWN = 4'd5;
	localparam logic [BTN_W-1:0] BTN_MIDDLE_UP   = 4'd6;
	localparam logic [BTN_W-1:0] BTN_WHEEL_DOWN  = 4'd7;
	localparam logic [BTN_W-1:0] BTN_WHEEL_UP    = 4'd8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_SPAN_X  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_SPAN_Y  = 2'd3;

	typedef struct packed {
		logic [1:0]              mode;
		logic [CODE_W-1:0]       event_code;
		logic signed [VAL_W-1:0] event_value;
	} pet_in_t;

	typedef struct packed {
		logic [DIM_W-1:0] pointer_x;
		logic [DIM_W-1:0] pointer_y;
		logic             moved;
		logic [BTN_W-1:0] button_event;
	} pet_out_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic exec;
		logic mul;
		logic fin;
		logic put;
	} pet_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scale;
		logic div_last;
	} pet_stat_t;
endpackage

### src/pet_div.sv
// Restoring divider, one quotient bit per cycle
module pet_div #(
	parameter int DIVIDEND_W = 49
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [DIVIDEND_W-1:0]         dividend,
	input  logic [pet_pkg::SPAN_W-1:0]    divisor,
	output logic                          last,
	output logic [DIVIDEND_W-1:0]         quotient
);
	import pet_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [CNT_W-1:0]      cnt_q;
	logic [SPAN_W-1:0]     rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [SPAN_W:0]       trial;
	logic [SPAN_W:0]       diff;

	// dividend bits shift out of the top of quo_q, quotient bits shift in
	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		diff  = trial - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIVIDEND_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			if (!diff[SPAN_W]) begin
				rem_q <= diff[SPAN_W-1:0];
			end else begin
				rem_q <= trial[SPAN_W-1:0];
			end
			quo_q <= {quo_q[DIVIDEND_W-2:0], ~diff[SPAN_W]};
		end
	end

	assign last     = (cnt_q == CNT_W'(1));
	assign quotient = quo_q;
endmodule

### src/pet_dp.sv
// Datapath: registers, pointer state, clamp, multiplier and divider
module pet_dp #(
	parameter int COORD_BITS = 16,
	parameter int ABS_BITS   = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pet_pkg::pet_in_t                  in_data,
	input  logic                              cfg_we,
	input  logic [pet_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pet_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  pet_pkg::pet_cmd_t                 cmd,
	output pet_pkg::pet_stat_t                stat,
	output pet_pkg::pet_out_t                 out_data
);
	import pet_pkg::*;

	localparam int CB     = COORD_BITS;
	localparam int AW     = ABS_BITS;
	localparam int MAG_W  = AW + 1;
	localparam int PROD_W = MAG_W + DIM_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int REL_W  = VAL_W + 2;
	localparam int CW     = (SUM_W > REL_W) ? SUM_W : REL_W;

	// limit is dim-1 (0 for dim 0), capped to the coordinate range
	function automatic logic [CB-1:0] clamp_coord(input logic signed [CW-1:0] v,
			input logic [DIM_W-1:0] dim);
		logic [DIM_W-1:0] lim_full;
		logic [CB-1:0]    lim;
		lim_full = (dim == '0) ? '0 : dim - DIM_W'(1);
		if ((lim_full >> CB) != '0) begin
			lim = '1;
		end else begin
			lim = lim_full[CB-1:0];
		end
		if (v < 0) begin
			clamp_coord = '0;
		end else if (v > $signed(CW'(lim))) begin
			clamp_coord = lim;
		end else begin
			clamp_coord = v[CB-1:0];
		end
	endfunction

	pet_in_t                in_q;
	logic [DIM_W-1:0]       width_q, height_q;
	logic [SPAN_W-1:0]      span_x_q, span_y_q;
	logic [CB-1:0]          pos_q [2];
	logic [CB-1:0]          org_pos_q [2];
	logic signed [AW-1:0]   last_abs_q [2];
	logic signed [AW-1:0]   org_abs_q [2];
	logic                   touching_q;
	logic                   moved_q;
	logic [BTN_W-1:0]       btn_q;
	logic                   neg_q;
	logic [MAG_W-1:0]       mag_q;
	pet_out_t               out_q;

	logic                   axis;
	logic                   is_axis;
	logic                   down;
	logic                   exec_moved;
	logic [BTN_W-1:0]       exec_btn;
	logic                   div_last;
	logic [DIM_W-1:0]       dim_sel;
	logic [SPAN_W-1:0]      span_sel;
	logic signed [AW-1:0]   abs_val;
	logic signed [MAG_W-1:0] diff;
	logic [MAG_W-1:0]       mag;
	logic signed [CW-1:0]   rel_sum;
	logic [PROD_W-1:0]      prod;
	logic [PROD_W-1:0]      quotient;
	logic signed [CW-1:0]   q_ext;
	logic signed [CW-1:0]   offset;
	logic signed [CW-1:0]   fin_sum;

	assign axis     = in_q.event_code[0];
	assign is_axis  = (in_q.event_code == CODE_AXIS_X) || (in_q.event_code == CODE_AXIS_Y);
	assign down     = (in_q.event_value != '0);
	assign dim_sel  = axis ? height_q : width_q;
	assign span_sel = axis ? span_y_q : span_x_q;
	assign abs_val  = in_q.event_value[AW-1:0];
	assign diff     = MAG_W'(abs_val) - MAG_W'(org_abs_q[axis]);
	assign mag      = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
	assign rel_sum  = $signed(CW'(pos_q[axis])) + CW'($signed(in_q.event_value));

	assign prod = PROD_W'(mag_q) * PROD_W'(dim_sel);

	// offset is truncated toward zero; a zero span gives no offset
	assign q_ext   = $signed(CW'(quotient));
	assign offset  = (span_sel == '0) ? '0 : (neg_q ? -q_ext : q_ext);
	assign fin_sum = offset + $signed(CW'(org_pos_q[axis]));

	assign stat.scale    = (in_q.mode == MODE_ABS) && is_axis && touching_q;
	assign stat.div_last = div_last;

	// moved flag and button code for the event being executed
	always_comb begin
		exec_moved = 1'b0;
		exec_btn   = BTN_NONE;
		case (in_q.mode)
			MODE_KEY: begin
				case (in_q.event_code)
					CODE_BTN_LEFT: begin
						exec_btn = down ? BTN_LEFT_DOWN : BTN_LEFT_UP;
					end
					CODE_BTN_RIGHT: begin
						exec_btn = down ? BTN_RIGHT_DOWN : BTN_RIGHT_UP;
					end
					CODE_BTN_MIDDLE: begin
						exec_btn = down ? BTN_MIDDLE_DOWN : BTN_MIDDLE_UP;
					end
					default: begin
					end
				endcase
			end
			MODE_REL: begin
				if (is_axis) begin
					exec_moved = 1'b1;
				end else if (in_q.event_code == CODE_REL_WHEEL) begin
					exec_btn = in_q.event_value[VAL_W-1] ? BTN_WHEEL_DOWN : BTN_WHEEL_UP;
				end
			end
			MODE_ABS: begin
				exec_moved = is_axis && touching_q;
			end
			default: begin
			end
		endcase
	end

	pet_div #(
		.DIVIDEND_W(PROD_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mul),
		.dividend (prod),
		.divisor  (span_sel),
		.last     (div_last),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q       <= DIM_W'(640);
			height_q      <= DIM_W'(480);
			span_x_q      <= SPAN_W'(4095);
			span_y_q      <= SPAN_W'(4095);
			pos_q[0]      <= '0;
			pos_q[1]      <= '0;
			org_pos_q[0]  <= '0;
			org_pos_q[1]  <= '0;
			last_abs_q[0] <= '0;
			last_abs_q[1] <= '0;
			org_abs_q[0]  <= '0;
			org_abs_q[1]  <= '0;
			touching_q    <= 1'b0;
			moved_q       <= 1'b0;
			btn_q         <= BTN_NONE;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SCREEN_WIDTH: begin
						width_q <= cfg_data[DIM_W-1:0];
					end
					CFG_SCREEN_HEIGHT: begin
						height_q <= cfg_data[DIM_W-1:0];
					end
					CFG_TOUCH_SPAN_X: begin
						span_x_q <= cfg_data[SPAN_W-1:0];
					end
					CFG_TOUCH_SPAN_Y: begin
						span_y_q <= cfg_data[SPAN_W-1:0];
					end
					default: begin
					end
				endcase
			end

			if (cmd.exec) begin
				moved_q <= exec_moved;
				btn_q   <= exec_btn;
				case (in_q.mode)
					MODE_KEY: begin
						case (in_q.event_code)
							CODE_BTN_FINGER, CODE_BTN_TOUCH: begin
								touching_q <= down;
								if (down) begin
									org_abs_q[0] <= last_abs_q[0];
									org_abs_q[1] <= last_abs_q[1];
									org_pos_q[0] <= pos_q[0];
									org_pos_q[1] <= pos_q[1];
								end
							end
							default: begin
							end
						endcase
					end
					MODE_REL: begin
						if (is_axis) begin
							pos_q[axis] <= clamp_coord(rel_sum, dim_sel);
						end
					end
					MODE_ABS: begin
						if (is_axis) begin
							last_abs_q[axis] <= abs_val;
						end
					end
					default: begin
					end
				endcase
			end

			if (cmd.fin) begin
				pos_q[axis] <= clamp_coord(fin_sum, dim_sel);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			in_q <= in_data;
		end
		if (cmd.exec) begin
			neg_q <= diff[MAG_W-1];
			mag_q <= mag;
		end
		if (cmd.put) begin
			out_q.pointer_x    <= DIM_W'(pos_q[0]);
			out_q.pointer_y    <= DIM_W'(pos_q[1]);
			out_q.moved        <= moved_q;
			out_q.button_event <= btn_q;
		end
	end

	assign out_data = out_q;
endmodule

### src/pet_ctrl.sv
// Controller: sequences decode, scaling and result handoff
module pet_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  pet_pkg::pet_stat_t    stat,
	output pet_pkg::pet_cmd_t     cmd
);
	import pet_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;
	localparam logic [2:0] ST_PUT  = 3'd5;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.take = in_valid && in_ready;
		cmd.exec = (state_q == ST_EXEC);
		cmd.mul  = (state_q == ST_MUL);
		cmd.fin  = (state_q == ST_FIN);
		// output register frees up when empty or drained this cycle
		cmd.put  = (state_q == ST_PUT) && (!out_valid_q || out_ready);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.take) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = stat.scale ? ST_MUL : ST_PUT;
			end
			ST_MUL: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = ST_PUT;
			end
			ST_PUT: begin
				if (cmd.put) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.put) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

### src/pointer_event_tracker.sv
// Pointer event tracker: input events in, pointer position and button code out
//
// Usage:
//   in channel  (in_valid/in_ready, in_data): one input event per request
//     (mode, event_code, event_value). Every accepted request yields exactly
//     one result request on the out channel, in order.
//   out channel (out_valid/out_ready, out_data): pointer_x, pointer_y,
//     moved and button_event after the event.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): register writes,
//     always ready; write only while no request is in flight.
// Timing:
//   Keys, relative moves, wheel, untouched absolute events: states EXEC then
//   PUT load the result; the next request is taken only after it is loaded.
//   Absolute X/Y while touching: states EXEC, MUL, DIV and FIN come before PUT,
//   with DIV set by the restoring divider that produces one quotient bit per
//   cycle over the (ABS_BITS+17)-bit product.
// Reset: position, touch state and origins clear to zero, registers return
//   to 640x480 screen and 4095 spans; no result is pending.
// Stall: a result held by out_ready low stays in the output register while
//   the next request is accepted and processed; that request then waits
//   for the output register before the block takes another.
module pointer_event_tracker #(
	parameter int COORD_BITS = 16,
	parameter int ABS_BITS   = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  pet_pkg::pet_in_t                  in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output pet_pkg::pet_out_t                 out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pet_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pet_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import pet_pkg::*;

	pet_cmd_t  cmd;
	pet_stat_t stat;

	// register writes complete in the cycle they are presented
	assign cfg_ready = 1'b1;

	pet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pet_dp #(
		.COORD_BITS (COORD_BITS),
		.ABS_BITS   (ABS_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (out_data)
	);
endmodule

### src/pet_chk.sv
// Port-level checks for the pointer event tracker, bound to the top level
`include "pointer_event_tracker_defines.svh"

module pet_chk (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input pet_pkg::pet_out_t     out_data
);
	import pet_pkg::*;

	// one request at a time: busy right after a request is taken
	`PET_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
	`PET_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`PET_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data))
	// a move never carries a button code
	`PET_ASSERT_NOW(a_move_no_btn, out_valid && out_data.moved, out_data.button_event == BTN_NONE)
	`PET_ASSERT_NOW(a_btn_range, out_valid, out_data.button_event <= BTN_WHEEL_UP)
endmodule

bind pointer_event_tracker pet_chk u_pet_chk (.*);

### tb/pointer_event_tracker_tb.sv
// Self-checking testbench for the pointer event tracker: directed and random event streams
module pointer_event_tracker_tb;
	import pet_pkg::*;

	// Mode 0 events and unlisted codes are ignored by the block
	localparam logic [1:0]        MODE_NONE       = 2'd0;
	localparam logic [CODE_W-1:0] CODE_REL_UNUSED = 10'd2;
	localparam logic [CODE_W-1:0] CODE_TOP        = 10'h3FF;

	localparam longint COORD_MAX       = (64'd1 << DIM_W) - 1;
	localparam int     PHASES          = 9;
	localparam int     ITEMS_PER_PHASE = 205;
	localparam int     QUIET_LIMIT     = 2000;
	localparam int     REPORT_MAX      = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  in_valid = 1'b0;
	logic                  in_ready;
	pet_in_t               in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	pet_out_t              out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	pointer_event_tracker DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Tracker model: register copies and pointer/touch state as they stand
	// after every accepted request. Values below match the block's reset.
	// ------------------------------------------------------------------
	logic [DIM_W-1:0]  scr_w = 16'd640;
	logic [DIM_W-1:0]  scr_h = 16'd480;
	logic [SPAN_W-1:0] span_x = 32'd4095;
	logic [SPAN_W-1:0] span_y = 32'd4095;

	logic [DIM_W-1:0] pos_x = '0;
	logic [DIM_W-1:0] pos_y = '0;
	logic             touch_down = 1'b0;
	longint           sensor_last[2] = '{0, 0};
	longint           sensor_origin[2] = '{0, 0};
	logic [DIM_W-1:0] pointer_origin[2] = '{16'd0, 16'd0};

	pet_in_t  pending_q[$];     // events waiting for the driver
	pet_out_t expected_q[$];    // predicted results, oldest first

	int          items_queued = 0;
	int          results_seen = 0;
	int          mismatches = 0;
	int          quiet_cycles = 0;
	logic        in_taken = 1'b0;
	logic        idling_on = 1'b0;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;

	// Clamp to [0, dim-1]; a zero dimension pins the axis at 0
	function automatic logic [DIM_W-1:0] clamp_pos(input longint v, input logic [DIM_W-1:0] dim);
		longint lim;
		lim = (dim != 0) ? longint'(dim) - 1 : 0;
		if (lim > COORD_MAX)
			lim = COORD_MAX;
		if (v < 0)
			return '0;
		if (v > lim)
			return lim[DIM_W-1:0];
		return v[DIM_W-1:0];
	endfunction

	// Touch move: origin + (a - a0) * dim / span, magnitude truncated so the
	// quotient rounds toward zero. Zero span leaves the pointer at its origin.
	function automatic logic [DIM_W-1:0] touch_target(input bit axis, input longint a,
			input logic [DIM_W-1:0] dim, input logic [SPAN_W-1:0] span);
		longint          diff;
		longint          off;
		longint unsigned mag;
		longint unsigned quo;
		diff = a - sensor_origin[axis];
		mag = (diff < 0) ? -diff : diff;
		off = 0;
		if (span != 0) begin
			quo = (mag * dim) / span;
			off = (diff < 0) ? -longint'(quo) : longint'(quo);
		end
		return clamp_pos(off + longint'(pointer_origin[axis]), dim);
	endfunction

	// Advance the model by one event and return the result it produces
	function automatic pet_out_t track_event(input pet_in_t ev);
		pet_out_t res;
		longint   val;
		logic     down;
		bit       axis;
		res = '0;
		val = longint'(ev.event_value);
		down = (ev.event_value != 0);
		axis = ev.event_code[0];
		case (ev.mode)
		MODE_KEY: begin
			case (ev.event_code)
			CODE_BTN_LEFT:   res.button_event = down ? BTN_LEFT_DOWN : BTN_LEFT_UP;
			CODE_BTN_RIGHT:  res.button_event = down ? BTN_RIGHT_DOWN : BTN_RIGHT_UP;
			CODE_BTN_MIDDLE: res.button_event = down ? BTN_MIDDLE_DOWN : BTN_MIDDLE_UP;
			CODE_BTN_FINGER, CODE_BTN_TOUCH: begin
				touch_down = down;
				// a press pins both the sensor and the pointer origin
				if (down) begin
					sensor_origin[0] = sensor_last[0];
					sensor_origin[1] = sensor_last[1];
					pointer_origin[0] = pos_x;
					pointer_origin[1] = pos_y;
				end
			end
			default: ;
			endcase
		end
		MODE_REL: begin
			case (ev.event_code)
			CODE_AXIS_X: begin
				pos_x = clamp_pos(longint'(pos_x) + val, scr_w);
				res.moved = 1'b1;
			end
			CODE_AXIS_Y: begin
				pos_y = clamp_pos(longint'(pos_y) + val, scr_h);
				res.moved = 1'b1;
			end
			CODE_REL_WHEEL: res.button_event = (val < 0) ? BTN_WHEEL_DOWN : BTN_WHEEL_UP;
			default: ;
			endcase
		end
		MODE_ABS: begin
			if (ev.event_code == CODE_AXIS_X || ev.event_code == CODE_AXIS_Y) begin
				// the sensor position is tracked whether or not a touch is active
				sensor_last[axis] = val;
				if (touch_down) begin
					if (axis)
						pos_y = touch_target(axis, val, scr_h, span_y);
					else
						pos_x = touch_target(axis, val, scr_w, span_x);
					res.moved = 1'b1;
				end
			end
		end
		default: ;
		endcase
		res.pointer_x = pos_x;
		res.pointer_y = pos_y;
		return res;
	endfunction

	// Mostly back-to-back, sometimes a short gap, rarely a long pause
	function automatic int unsigned next_gap();
		int unsigned r;
		if (!idling_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(20, 90);
	endfunction

	// Idling comes and goes in random stretches
	always @(posedge clk) begin
		if ($urandom_range(0, 299) == 0)
			idling_on <= !idling_on;
	end

	// ------------------------------------------------------------------
	// Request driver: presents queued events at the falling edge and holds
	// each one until the rising edge that accepts it.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_q.size() != 0) begin
				in_valid <= 1'b1;
				in_data <= pending_q.pop_front();
				send_gap <= next_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result side back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			stall_left <= next_gap();
		end
	end

	// ------------------------------------------------------------------
	// Monitor: at each rising edge, apply register writes to the model,
	// predict accepted events, check results in order, and run the watchdog.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		pet_out_t want;
		logic     bad;
		in_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_SCREEN_WIDTH:  scr_w = cfg_data[DIM_W-1:0];
				CFG_SCREEN_HEIGHT: scr_h = cfg_data[DIM_W-1:0];
				CFG_TOUCH_SPAN_X:  span_x = cfg_data[SPAN_W-1:0];
				CFG_TOUCH_SPAN_Y:  span_y = cfg_data[SPAN_W-1:0];
				default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_q.push_back(track_event(in_data));
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("unexpected result: x=%0d y=%0d moved=%0d btn=%0d",
							out_data.pointer_x, out_data.pointer_y, out_data.moved,
							out_data.button_event);
				end else begin
					want = expected_q.pop_front();
					results_seen++;
					bad = (out_data.pointer_x !== want.pointer_x)
						|| (out_data.pointer_y !== want.pointer_y)
						|| (out_data.moved !== want.moved)
						|| (out_data.button_event !== want.button_event);
					if (bad) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("result %0d mismatch: exp x=%0d y=%0d moved=%0d btn=%0d, got x=%0d y=%0d moved=%0d btn=%0d",
								results_seen, want.pointer_x, want.pointer_y, want.moved,
								want.button_event, out_data.pointer_x, out_data.pointer_y,
								out_data.moved, out_data.button_event);
					end
				end
			end
		end
		// watchdog: any handshake on any channel counts as progress
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", quiet_cycles);
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_event(input logic [1:0] m, input logic [CODE_W-1:0] c,
			input logic [VAL_W-1:0] v);
		pet_in_t ev;
		ev.mode = m;
		ev.event_code = c;
		ev.event_value = v;
		pending_q.push_back(ev);
		items_queued++;
	endtask

	// Sensor coordinate: mostly a realistic panel range, sometimes anything
	function automatic logic [VAL_W-1:0] abs_coord();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(0, 8191);
		if (r < 90)
			return $urandom();
		case ($urandom_range(0, 3))
		0: return 32'h7FFF_FFFF;
		1: return 32'h8000_0000;
		2: return 32'hFFFF_FFFF;
		default: return 32'h0;
		endcase
	endfunction

	// Relative delta: small both ways, sometimes huge to hit the clamps
	function automatic logic [VAL_W-1:0] rel_delta();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return 32'($urandom_range(0, 400)) - 32'd200;
		if (r < 95)
			return $urandom();
		return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
	endfunction

	// One burst of related events; n counts the ones that do something
	task automatic queue_burst(output int unsigned n);
		int unsigned      r;
		int unsigned      k;
		logic [VAL_W-1:0] v;
		r = $urandom_range(0, 99);
		n = 0;
		if (r < 40) begin
			// touch gesture: optional approach, press, drag, usually a release
			if ($urandom_range(0, 1)) begin
				push_event(MODE_ABS, CODE_AXIS_X, abs_coord());
				push_event(MODE_ABS, CODE_AXIS_Y, abs_coord());
				n += 2;
			end
			v = $urandom_range(0, 1) ? 32'd1 : $urandom();
			if (v == 0)
				v = 32'd1;
			push_event(MODE_KEY, $urandom_range(0, 1) ? CODE_BTN_TOUCH : CODE_BTN_FINGER, v);
			k = $urandom_range(1, 10);
			repeat (k) begin
				if ($urandom_range(0, 9) == 0)
					push_event(MODE_REL, $urandom_range(0, 1) ? CODE_AXIS_Y : CODE_AXIS_X,
						rel_delta());
				else
					push_event(MODE_ABS, $urandom_range(0, 1) ? CODE_AXIS_Y : CODE_AXIS_X,
						abs_coord());
			end
			n += k + 1;
			if ($urandom_range(0, 9) != 0) begin
				push_event(MODE_KEY, $urandom_range(0, 1) ? CODE_BTN_TOUCH : CODE_BTN_FINGER,
					32'd0);
				n++;
			end
		end else if (r < 65) begin
			k = $urandom_range(1, 6);
			repeat (k)
				push_event(MODE_REL, $urandom_range(0, 1) ? CODE_AXIS_Y : CODE_AXIS_X,
					rel_delta());
			n += k;
		end else if (r < 78) begin
			case ($urandom_range(0, 2))
			0: v = {22'd0, CODE_BTN_LEFT};
			1: v = {22'd0, CODE_BTN_RIGHT};
			default: v = {22'd0, CODE_BTN_MIDDLE};
			endcase
			push_event(MODE_KEY, v[CODE_W-1:0], $urandom_range(0, 1) ? 32'd1 : ($urandom() | 32'd1));
			push_event(MODE_KEY, v[CODE_W-1:0], 32'd0);
			n += 2;
		end else if (r < 86) begin
			push_event(MODE_REL, CODE_REL_WHEEL, $urandom_range(0, 1) ? rel_delta() : $urandom());
			n++;
		end else begin
			// noise: any mode, any code, any value
			push_event(2'($urandom_range(0, 3)), CODE_W'($urandom_range(0, 1023)), $urandom());
		end
	endtask

	// Register write; cfg_valid stays up for back-to-back writes
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Every request gives one result, so idle means all results are back
	task automatic wait_idle();
		do @(negedge clk); while (results_seen != items_queued);
		repeat (8) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		logic [DIM_W-1:0]  w;
		logic [DIM_W-1:0]  h;
		logic [SPAN_W-1:0] sx;
		logic [SPAN_W-1:0] sy;
		int unsigned       got;
		int unsigned       burst_n;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass at the reset geometry (640x480, spans 4095)
		push_event(MODE_NONE, CODE_AXIS_X, 32'd5);
		push_event(MODE_KEY, CODE_BTN_LEFT, 32'd1);
		push_event(MODE_KEY, CODE_BTN_LEFT, 32'd0);
		push_event(MODE_KEY, CODE_BTN_RIGHT, 32'hFFFF_FFFF);
		push_event(MODE_KEY, CODE_BTN_RIGHT, 32'd0);
		push_event(MODE_KEY, CODE_BTN_MIDDLE, 32'h8000_0000);
		push_event(MODE_KEY, CODE_BTN_MIDDLE, 32'd0);
		push_event(MODE_KEY, CODE_TOP, 32'd1);
		push_event(MODE_REL, CODE_AXIS_X, 32'd100);
		push_event(MODE_REL, CODE_AXIS_Y, 32'd7);
		push_event(MODE_REL, CODE_AXIS_X, 32'h8000_0000);     // clamps low
		push_event(MODE_REL, CODE_AXIS_Y, 32'h7FFF_FFFF);     // clamps high
		push_event(MODE_REL, CODE_REL_WHEEL, 32'hFFFF_FFFF);
		push_event(MODE_REL, CODE_REL_WHEEL, 32'd0);
		push_event(MODE_REL, CODE_REL_UNUSED, 32'd9);
		// absolute while untouched only records the sensor position
		push_event(MODE_ABS, CODE_AXIS_X, 32'd2000);
		push_event(MODE_ABS, CODE_AXIS_Y, 32'h8000_0000);
		push_event(MODE_KEY, CODE_BTN_TOUCH, 32'd1);
		push_event(MODE_ABS, CODE_AXIS_X, 32'd4095);
		push_event(MODE_ABS, CODE_AXIS_Y, 32'h7FFF_FFFF);
		push_event(MODE_ABS, CODE_REL_UNUSED, 32'd77);
		push_event(MODE_KEY, CODE_BTN_FINGER, 32'd0);
		push_event(MODE_ABS, CODE_AXIS_X, 32'd0);
		push_event(MODE_KEY, CODE_BTN_FINGER, 32'd5);
		push_event(MODE_ABS, CODE_AXIS_X, 32'h8000_0000);     // large negative drag
		push_event(MODE_KEY, CODE_BTN_TOUCH, 32'd0);
		wait_idle();

		// Random phases, each under its own geometry; extremes first,
		// reset geometry last
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
			0: begin
				w = 16'd1; h = 16'd1; sx = 32'd0; sy = 32'd0;
			end
			1: begin
				w = 16'hFFFF; h = 16'hFFFF; sx = 32'hFFFF_FFFF; sy = 32'hFFFF_FFFF;
			end
			2: begin
				w = 16'd0; h = 16'd0; sx = 32'd1; sy = 32'd1;
			end
			3: begin
				w = 16'd1920; h = 16'd1080; sx = 32'd4095; sy = 32'd2047;
			end
			4: begin
				w = 16'hFFFF; h = 16'd1; sx = 32'd1; sy = 32'hFFFF_FFFF;
			end
			8: begin
				w = 16'd640; h = 16'd480; sx = 32'd4095; sy = 32'd4095;
			end
			default: begin
				w = DIM_W'($urandom_range(1, 65535));
				h = DIM_W'($urandom_range(1, 65535));
				sx = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom();
				sy = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom();
			end
			endcase
			// upper data bits are don't-care for the 16-bit screen registers
			write_reg(CFG_SCREEN_WIDTH, {16'($urandom()), w});
			write_reg(CFG_SCREEN_HEIGHT, {16'($urandom()), h});
			write_reg(CFG_TOUCH_SPAN_X, sx);
			write_reg(CFG_TOUCH_SPAN_Y, sy);
			@(negedge clk);
			cfg_valid <= 1'b0;

			// fill at a rising edge so the driver never races the queue
			@(posedge clk);
			got = 0;
			while (got < ITEMS_PER_PHASE) begin
				queue_burst(burst_n);
				got += burst_n;
			end
			wait_idle();
		end

		repeat (60) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
